// ----- hw/rtl/esd_pkg.sv -----
// Shared types and character codes for the escape sequence decoder.
package esd_pkg;

	typedef enum logic [1:0] {
		MODE_PLAIN = 2'd0,
		MODE_ESC   = 2'd1,
		MODE_HEX0  = 2'd2,
		MODE_HEX1  = 2'd3
	} mode_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_end;
		logic       string_end;
	} result_t;

	typedef struct packed {
		result_t    res0;
		result_t    res1;
		logic       two;
		mode_t      next_mode;
		logic [3:0] next_nibble;
	} decode_t;

	localparam int unsigned FifoDepth = 4;
	localparam int unsigned PtrW      = $clog2(FifoDepth);
	localparam int unsigned CntW      = $clog2(FifoDepth + 1);

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_X_LOWER   = 8'h78;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_N         = 8'h6E;
	localparam logic [7:0] CH_R         = 8'h72;
	localparam logic [7:0] CH_T         = 8'h74;
	localparam logic [7:0] CH_V         = 8'h76;
	localparam logic [7:0] CH_F         = 8'h66;
	localparam logic [7:0] CH_B         = 8'h62;
	localparam logic [7:0] CH_A         = 8'h61;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_NINE      = 8'h39;
	localparam logic [7:0] CH_A_LOWER   = 8'h61;
	localparam logic [7:0] CH_F_LOWER   = 8'h66;
	localparam logic [7:0] CH_A_UPPER   = 8'h41;
	localparam logic [7:0] CH_F_UPPER   = 8'h46;
	localparam logic [7:0] CTL_CR       = 8'h0D;
	localparam logic [7:0] CTL_TAB      = 8'h09;
	localparam logic [7:0] CTL_VTAB     = 8'h0B;
	localparam logic [7:0] CTL_FF       = 8'h0C;
	localparam logic [7:0] CTL_BS       = 8'h08;
	localparam logic [7:0] CTL_BEL      = 8'h07;
	localparam logic [7:0] CTL_NUL      = 8'h00;

endpackage

// ----- hw/rtl/esd_in_if.sv -----
// Request channel carrying one raw byte of an escaped string.
interface esd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       is_final;

	modport source (output valid, output in_byte, output is_final, input ready);
	modport sink (input valid, input in_byte, input is_final, output ready);
endinterface

// ----- hw/rtl/esd_out_if.sv -----
// Request channel carrying one decoded result.
interface esd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       run_end;
	logic       string_end;

	modport source (output valid, output out_byte, output byte_valid, output run_end,
		output string_end, input ready);
	modport sink (input valid, input out_byte, input byte_valid, input run_end,
		input string_end, output ready);
endinterface

// ----- hw/rtl/esd_decode.sv -----
// Combinational decode of one raw byte against the current escape state.
module esd_decode (
	input  esd_pkg::mode_t   mode,
	input  logic [3:0]       nibble,
	input  logic [7:0]       in_byte,
	input  logic             is_final,
	output esd_pkg::decode_t dec
);
	import esd_pkg::*;

	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [7:0] t;
		t = 8'h00;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			t = c - CH_ZERO;
			return {1'b1, t[3:0]};
		end
		if (c >= CH_A_LOWER && c <= CH_F_LOWER) begin
			t = c - CH_A_LOWER + 8'd10;
			return {1'b1, t[3:0]};
		end
		if (c >= CH_A_UPPER && c <= CH_F_UPPER) begin
			t = c - CH_A_UPPER + 8'd10;
			return {1'b1, t[3:0]};
		end
		return 5'b0_0000;
	endfunction

	logic [4:0] hv;
	logic       pre_v;
	logic [7:0] pre_b;
	logic       main_v;
	logic [7:0] main_b;
	logic       do_plain;
	mode_t      nm;
	logic [3:0] nn;

	assign hv = hex_value(in_byte);

	always_comb begin
		pre_v    = 1'b0;
		pre_b    = 8'h00;
		main_v   = 1'b0;
		main_b   = 8'h00;
		do_plain = 1'b0;
		nm       = MODE_PLAIN;
		nn       = nibble;
		unique case (mode)
			MODE_PLAIN: begin
				do_plain = 1'b1;
			end
			MODE_ESC: begin
				unique case (in_byte)
					CH_N: begin main_v = 1'b1; main_b = CH_NEWLINE; end
					CH_R: begin main_v = 1'b1; main_b = CTL_CR; end
					CH_T: begin main_v = 1'b1; main_b = CTL_TAB; end
					CH_V: begin main_v = 1'b1; main_b = CTL_VTAB; end
					CH_F: begin main_v = 1'b1; main_b = CTL_FF; end
					CH_B: begin main_v = 1'b1; main_b = CTL_BS; end
					CH_A: begin main_v = 1'b1; main_b = CTL_BEL; end
					CH_ZERO: begin main_v = 1'b1; main_b = CTL_NUL; end
					CH_NEWLINE: begin
						main_v = 1'b0;
					end
					CH_X_LOWER: begin
						if (is_final) begin
							main_v = 1'b1;
							main_b = CH_X_LOWER;
						end else begin
							nm = MODE_HEX0;
						end
					end
					default: begin
						main_v = 1'b1;
						main_b = in_byte;
					end
				endcase
			end
			MODE_HEX0: begin
				if (hv[4]) begin
					if (is_final) begin
						main_v = 1'b1;
						main_b = {4'h0, hv[3:0]};
					end else begin
						nn = hv[3:0];
						nm = MODE_HEX1;
					end
				end else begin
					pre_v    = 1'b1;
					pre_b    = CH_X_LOWER;
					do_plain = 1'b1;
				end
			end
			MODE_HEX1: begin
				if (hv[4]) begin
					main_v = 1'b1;
					main_b = {nibble, hv[3:0]};
				end else begin
					pre_v    = 1'b1;
					pre_b    = {4'h0, nibble};
					do_plain = 1'b1;
				end
			end
			default: begin
				do_plain = 1'b1;
			end
		endcase

		if (do_plain) begin
			if (in_byte == CH_BACKSLASH && !is_final) begin
				nm = MODE_ESC;
			end else begin
				main_v = 1'b1;
				main_b = in_byte;
			end
		end

		if (nm != MODE_HEX1) begin
			nn = 4'h0;
		end
		if (is_final) begin
			nm = MODE_PLAIN;
			nn = 4'h0;
		end

		dec.next_mode   = nm;
		dec.next_nibble = nn;
		dec.two         = pre_v & main_v;
		dec.res1        = '{out_byte: main_b, byte_valid: 1'b1, run_end: 1'b1,
			string_end: is_final};
		if (pre_v) begin
			dec.res0 = '{out_byte: pre_b, byte_valid: 1'b1, run_end: !main_v,
				string_end: !main_v && is_final};
		end else if (main_v) begin
			dec.res0 = '{out_byte: main_b, byte_valid: 1'b1, run_end: 1'b1,
				string_end: is_final};
		end else begin
			dec.res0 = '{out_byte: 8'h00, byte_valid: 1'b0, run_end: 1'b1,
				string_end: is_final};
		end
	end
endmodule

// ----- hw/rtl/esd_result_fifo.sv -----
// Small result queue that takes one or two results per push and drains one per cycle while the receiver is ready.
module esd_result_fifo (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic                       push_two,
	input  esd_pkg::result_t           wdata0,
	input  esd_pkg::result_t           wdata1,
	output logic                       room_two,
	output logic [esd_pkg::CntW-1:0]   level,
	esd_out_if.source                  dec
);
	import esd_pkg::*;

	result_t             mem_q [FifoDepth];
	logic [PtrW-1:0]     wr_ptr_q;
	logic [PtrW-1:0]     rd_ptr_q;
	logic [CntW-1:0]     cnt_q;
	logic                pop;
	logic [PtrW-1:0]     wr_ptr_next1;
	logic [CntW-1:0]     n_push;

	assign pop          = dec.valid && dec.ready;
	assign wr_ptr_next1 = wr_ptr_q + PtrW'(1);
	assign n_push       = push ? (push_two ? CntW'(2) : CntW'(1)) : CntW'(0);
	assign room_two     = cnt_q <= CntW'(FifoDepth - 2);
	assign level        = cnt_q;

	assign dec.valid      = cnt_q != CntW'(0);
	assign dec.out_byte   = mem_q[rd_ptr_q].out_byte;
	assign dec.byte_valid = mem_q[rd_ptr_q].byte_valid;
	assign dec.run_end    = mem_q[rd_ptr_q].run_end;
	assign dec.string_end = mem_q[rd_ptr_q].string_end;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata0;
			if (push_two) begin
				mem_q[wr_ptr_next1] <= wdata1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PtrW'(n_push);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			cnt_q <= cnt_q + n_push - (pop ? CntW'(1) : CntW'(0));
		end
	end
endmodule

// ----- hw/rtl/escape_sequence_decoder_unit.sv -----
// Top level of the escape sequence decoder: input stage, decode state and result queue.
//
// The raw channel takes one byte of an escaped C string per request, with
// is_final set on the last byte of the string. The dec channel gives the
// decoded results in order: each input byte causes one or two results, and
// run_end marks the last result of each input byte. A result with
// byte_valid low carries no byte, as for an opening backslash or a first
// hex digit.
// A byte is registered in the input stage, then decoded and written into the
// result queue once it has room for two results, and shown on dec from then
// on. Throughput is one byte per cycle while the queue has room, set by the
// single decode stage and the one-result-per-cycle output; an input that
// gives two results takes a further output slot, which the four-entry queue absorbs.
// Reset clears the input stage, the queue and the decode state to plain text.
// When the receiver stalls, the queue fills and raw.ready drops while a byte waits
// in the input stage with fewer than two entries free; no result is dropped.
module escape_sequence_decoder_unit (
	input  logic     clk,
	input  logic     arst_n,
	esd_in_if.sink   raw,
	esd_out_if.source dec
);
	import esd_pkg::*;

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            fin_s1;
	mode_t           mode_q;
	logic [3:0]      nibble_q;
	decode_t         dec_res;
	logic            room_two;
	logic            push;
	logic [CntW-1:0] level;

	assign push      = valid_s1 && room_two;
	assign raw.ready = !valid_s1 || push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (raw.valid && raw.ready) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (raw.valid && raw.ready) begin
			byte_s1 <= raw.in_byte;
			fin_s1  <= raw.is_final;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_PLAIN;
			nibble_q <= 4'h0;
		end else if (push) begin
			mode_q   <= dec_res.next_mode;
			nibble_q <= dec_res.next_nibble;
		end
	end

	esd_decode u_decode (
		.mode     (mode_q),
		.nibble   (nibble_q),
		.in_byte  (byte_s1),
		.is_final (fin_s1),
		.dec      (dec_res)
	);

	esd_result_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_two (dec_res.two),
		.wdata0   (dec_res.res0),
		.wdata1   (dec_res.res1),
		.room_two (room_two),
		.level    (level),
		.dec      (dec)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		level <= CntW'(FifoDepth))
		else $error("Result queue holds more entries than it has.");

	assert property (@(posedge clk) disable iff (!arst_n)
		push && fin_s1 |=> mode_q == MODE_PLAIN && nibble_q == 4'h0)
		else $error("Decode state was not cleared after the final byte of a string.");

	assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != MODE_HEX1 |-> nibble_q == 4'h0)
		else $error("Held nibble is set outside the second hex digit state.");

	assert property (@(posedge clk) disable iff (!arst_n)
		push && dec_res.two |-> !dec_res.res0.run_end && dec_res.res1.run_end)
		else $error("A two-result byte has run_end on the wrong result.");
endmodule

// ----- test/escape_sequence_decoder_checker.sv -----
// Checker that predicts the decoded results from the raw requests and compares them.
`timescale 1ns / 100ps

module escape_sequence_decoder_checker (
	input  logic clk,
	input  logic arst_n,
	esd_in_if    raw,
	esd_out_if   dec,
	output int   mismatches,
	output int   pending
);
	import esd_pkg::*;

	mode_t      mode;
	logic [3:0] nibble;
	logic [7:0] decoded_bytes[$];
	result_t    expected_results[$];

	function automatic logic hex_value(input logic [7:0] c, output logic [3:0] v);
		hex_value = 1'b1;
		v = 4'h0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			v = 4'(c - CH_ZERO);
		end else if (c >= CH_A_LOWER && c <= CH_F_LOWER) begin
			v = 4'(c - CH_A_LOWER + 8'd10);
		end else if (c >= CH_A_UPPER && c <= CH_F_UPPER) begin
			v = 4'(c - CH_A_UPPER + 8'd10);
		end else begin
			hex_value = 1'b0;
		end
	endfunction

	task plain_text(input logic [7:0] c, input logic fin);
		if (c == CH_BACKSLASH && !fin) begin
			mode = MODE_ESC;
		end else begin
			decoded_bytes.push_back(c);
			mode = MODE_PLAIN;
		end
	endtask

	task escaped_char(input logic [7:0] c, input logic fin);
		mode = MODE_PLAIN;
		case (c)
			CH_N: decoded_bytes.push_back(CH_NEWLINE);
			CH_R: decoded_bytes.push_back(CTL_CR);
			CH_T: decoded_bytes.push_back(CTL_TAB);
			CH_V: decoded_bytes.push_back(CTL_VTAB);
			CH_F: decoded_bytes.push_back(CTL_FF);
			CH_B: decoded_bytes.push_back(CTL_BS);
			CH_A: decoded_bytes.push_back(CTL_BEL);
			CH_ZERO: decoded_bytes.push_back(CTL_NUL);
			CH_NEWLINE: ;
			CH_X_LOWER: begin
				if (fin) decoded_bytes.push_back(CH_X_LOWER);
				else mode = MODE_HEX0;
			end
			default: decoded_bytes.push_back(c);
		endcase
	endtask

	task predict_decode(input logic [7:0] c, input logic fin);
		result_t    r;
		logic [3:0] d;
		logic       hex_ok;
		decoded_bytes.delete();
		hex_ok = hex_value(c, d);
		case (mode)
			MODE_PLAIN: plain_text(c, fin);
			MODE_ESC: escaped_char(c, fin);
			MODE_HEX0: begin
				if (hex_ok) begin
					if (fin) begin
						decoded_bytes.push_back({4'h0, d});
						mode = MODE_PLAIN;
					end else begin
						nibble = d;
						mode = MODE_HEX1;
					end
				end else begin
					decoded_bytes.push_back(CH_X_LOWER);
					plain_text(c, fin);
				end
			end
			default: begin
				if (hex_ok) begin
					decoded_bytes.push_back({nibble, d});
					mode = MODE_PLAIN;
				end else begin
					decoded_bytes.push_back({4'h0, nibble});
					plain_text(c, fin);
				end
			end
		endcase
		if (mode != MODE_HEX1) nibble = 4'h0;
		if (fin) begin
			mode = MODE_PLAIN;
			nibble = 4'h0;
		end
		if (decoded_bytes.size() == 0) begin
			r.out_byte = 8'h00;
			r.byte_valid = 1'b0;
			r.run_end = 1'b1;
			r.string_end = fin;
			expected_results.push_back(r);
		end else begin
			foreach (decoded_bytes[k]) begin
				r.out_byte = decoded_bytes[k];
				r.byte_valid = 1'b1;
				r.run_end = (k == decoded_bytes.size() - 1);
				r.string_end = r.run_end && fin;
				expected_results.push_back(r);
			end
		end
	endtask

	task compare_result();
		result_t exp_r;
		if (expected_results.size() == 0) begin
			$error("Unexpected result: out_byte %0h byte_valid %0b run_end %0b string_end %0b",
				dec.out_byte, dec.byte_valid, dec.run_end, dec.string_end);
			mismatches <= mismatches + 1;
		end else begin
			exp_r = expected_results.pop_front();
			if (dec.out_byte !== exp_r.out_byte || dec.byte_valid !== exp_r.byte_valid ||
				dec.run_end !== exp_r.run_end || dec.string_end !== exp_r.string_end) begin
				mismatches <= mismatches + 1;
			end
			if (dec.out_byte !== exp_r.out_byte)
				$error("out_byte: expected %0h, actual %0h", exp_r.out_byte, dec.out_byte);
			if (dec.byte_valid !== exp_r.byte_valid)
				$error("byte_valid: expected %0b, actual %0b", exp_r.byte_valid, dec.byte_valid);
			if (dec.run_end !== exp_r.run_end)
				$error("run_end: expected %0b, actual %0b", exp_r.run_end, dec.run_end);
			if (dec.string_end !== exp_r.string_end)
				$error("string_end: expected %0b, actual %0b", exp_r.string_end, dec.string_end);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode = MODE_PLAIN;
			nibble = 4'h0;
			expected_results.delete();
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (raw.valid && raw.ready) predict_decode(raw.in_byte, raw.is_final);
			if (dec.valid && dec.ready) compare_result();
			pending <= expected_results.size();
		end
	end

endmodule

// ----- test/escape_sequence_decoder_unit_test.sv -----
// Top of the escape sequence decoder test: clock, reset, request traffic and verdict.
`timescale 1ns / 100ps

module escape_sequence_decoder_unit_test;
	import esd_pkg::*;

	localparam logic [7:0] ESC_CHARS [12] = '{CH_N, CH_R, CH_T, CH_V, CH_F, CH_B, CH_A,
		CH_ZERO, 8'h22, 8'h27, CH_BACKSLASH, CH_NEWLINE};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   mismatches;
	int   pending;
	logic [7:0] stim_byte[$];
	logic       stim_fin[$];

	esd_in_if  raw_if ();
	esd_out_if dec_if ();

	escape_sequence_decoder_unit u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.raw   (raw_if),
		.dec   (dec_if)
	);

	escape_sequence_decoder_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.raw       (raw_if),
		.dec       (dec_if),
		.mismatches(mismatches),
		.pending   (pending)
	);

	always #5 clk = ~clk;

	task add_item(input logic [7:0] b, input logic fin);
		stim_byte.push_back(b);
		stim_fin.push_back(fin);
	endtask

	initial begin
		raw_if.valid = 1'b0;
		raw_if.in_byte = 8'h00;
		raw_if.is_final = 1'b0;
		dec_if.ready = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	// The receiver stalls per result and once holds off long enough to back up the input.
	initial begin
		int stall;
		int taken;
		logic no_stall;
		taken = 0;
		no_stall = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			stall = no_stall ? 0 : $urandom_range(0, 8);
			if (taken == 300) stall = 80;
			if (stall > 0) begin
				dec_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			dec_if.ready <= 1'b1;
			@(posedge clk);
			while (!dec_if.valid) @(posedge clk);
			taken++;
			if (taken % 64 == 0) no_stall = ($urandom_range(0, 3) == 0);
		end
	end

	initial begin
		logic [7:0] cur[$];
		int n_elems;
		int kind;
		int d;
		int gap;
		logic burst;

		add_item(8'h00, 1'b0);
		add_item(8'hFF, 1'b0);
		add_item(CH_BACKSLASH, 1'b0);
		add_item(CH_N, 1'b0);
		add_item(CH_BACKSLASH, 1'b0);
		add_item(CH_X_LOWER, 1'b0);
		add_item(8'h34, 1'b0);
		add_item(8'h31, 1'b0);
		add_item(CH_BACKSLASH, 1'b0);
		add_item(CH_X_LOWER, 1'b0);
		add_item(CH_F_LOWER, 1'b0);
		add_item(8'h67, 1'b0);
		add_item(CH_BACKSLASH, 1'b0);
		add_item(CH_X_LOWER, 1'b0);
		add_item(8'h5A, 1'b0);
		add_item(CH_BACKSLASH, 1'b0);
		add_item(CH_NEWLINE, 1'b0);
		add_item(CH_BACKSLASH, 1'b0);
		add_item(8'h71, 1'b0);
		add_item(CH_BACKSLASH, 1'b1);
		add_item(CH_BACKSLASH, 1'b0);
		add_item(CH_X_LOWER, 1'b1);
		add_item(CH_BACKSLASH, 1'b0);
		add_item(CH_X_LOWER, 1'b0);
		add_item(CH_F_UPPER, 1'b1);

		// Random strings: mostly escape sequences, some of them cut short by the string end.
		while (stim_byte.size() < 825) begin
			cur.delete();
			n_elems = $urandom_range(1, 8);
			for (int k = 0; k < n_elems; k++) begin
				kind = $urandom_range(0, 9);
				if (kind < 4) begin
					cur.push_back(8'($urandom_range(0, 255)));
				end else if (kind < 7) begin
					cur.push_back(CH_BACKSLASH);
					d = $urandom_range(0, 12);
					if (d == 12) cur.push_back(8'($urandom_range(0, 255)));
					else cur.push_back(ESC_CHARS[d]);
				end else begin
					cur.push_back(CH_BACKSLASH);
					cur.push_back(CH_X_LOWER);
					repeat ($urandom_range(0, 2)) begin
						d = $urandom_range(0, 15);
						if (d < 10) cur.push_back(8'(CH_ZERO + d));
						else if ($urandom_range(0, 1) == 1) cur.push_back(8'(CH_A_UPPER + d - 10));
						else cur.push_back(8'(CH_A_LOWER + d - 10));
					end
				end
			end
			if (cur.size() > 1 && $urandom_range(0, 3) == 0) void'(cur.pop_back());
			foreach (cur[k]) add_item(cur[k], k == cur.size() - 1);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		burst = 1'b0;
		foreach (stim_byte[i]) begin
			if (i % 40 == 0) burst = ($urandom_range(0, 3) == 0);
			gap = burst ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				raw_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			raw_if.valid <= 1'b1;
			raw_if.in_byte <= stim_byte[i];
			raw_if.is_final <= stim_fin[i];
			@(posedge clk);
			while (!raw_if.ready) @(posedge clk);
		end
		raw_if.valid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
